>>> sv/amt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amt_pkg
// shared constants, register map and state type of the adaptive threshold
// ---------------------------------------------------------------------------
package amt_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HALF_DEF  = 15;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 11;
  localparam int CFG_W      = 17;
  localparam int CFG_ADDR_W = 3;
  localparam int GAIN_W     = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_HEIGHT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RATIO_Q16    = 3'd4;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd480;
  localparam logic [3:0]  HALF_HEIGHT_RST  = 4'd10;
  localparam logic [3:0]  HALF_WIDTH_RST   = 4'd10;
  localparam logic [16:0] RATIO_Q16_RST    = 17'd9830;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  localparam logic MODE_PIXEL = 1'b0;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_TAIL,
    B_MUL,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

>>> sv/adaptive_mean_threshold.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adaptive_mean_threshold
// local mean binarization of a raster grey pixel stream
// ---------------------------------------------------------------------------
// s channel: one transfer per item, tuser = 0 pixel, tuser = 1 drain.
// m channel: one transfer per result, tdata 0 or 255, tlast on the frame's
// last pixel. results lag the pixels by about h rows and w columns; drain
// items after the frame flush the remaining results.
// an item that yields no result keeps s_tready high. an item that
// yields a result holds s_tready low until the back end is done: it reads
// the clipped window from the row store one pixel per cycle through its
// single read port, then multiplies and compares.
// a result waiting in the output register does not block the next item;
// only the following result waits on m_tready.
// config writes (cfg_wen) take effect at once and restart the frame.
// reset: registers to defaults, counters to zero; the row store is not
// cleared since every entry read was written earlier in the frame.
// ---------------------------------------------------------------------------
module adaptive_mean_threshold
  import amt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_HALF  = MAX_HALF_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,   // pixel_in
  input  wire logic                  s_tuser,   // mode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [PIX_W-1:0]           m_tdata,   // binary_out
  output logic                       m_tlast
);

  localparam int SLOTS  = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int AW     = $clog2(SLOTS * MAX_WIDTH);
  localparam int DIM_W  = $clog2(2 * MAX_HALF + 2);

  typedef struct packed {
    logic [ROW_W-1:0]  tr;
    logic [ROW_W-1:0]  br;
    logic [WD_W-1:0]   tc;
    logic [WD_W-1:0]   bc;
    logic [ROW_W-1:0]  orow;
    logic [WD_W-1:0]   ocol;
    logic [SLOT_W-1:0] tslot;
    logic [DIM_W-1:0]  nrows;
    logic [DIM_W-1:0]  ncols;
    logic [GAIN_W-1:0] gain;
    logic              last;
  } job_t;

  job_t             job, q_head;
  logic             push, pop, q_empty, back_busy;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  amt_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .job_t     (job_t)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_empty   (q_empty),
    .back_busy (back_busy),
    .push      (push),
    .job       (job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  amt_queue #(
    .item_t (job_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (job),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  amt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SLOTS * MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  amt_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .job_t     (job_t)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .busy      (back_busy),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

>>> sv/amt_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amt_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/amt_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amt_queue
// two entry job queue between front and back
// ---------------------------------------------------------------------------
module amt_queue #(
  parameter type item_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic do_push;
  assign do_push = push && (count != 2'd2);
  assign empty   = (count == 2'd0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

>>> sv/amt_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amt_front
// config registers, pixel store writes and window job issue
// ---------------------------------------------------------------------------
module amt_front
  import amt_pkg::*;
#(
  parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int  MAX_HALF  = MAX_HALF_DEF,
  parameter type job_t     = logic
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  q_empty,
  input  wire logic                  back_busy,
  output logic                       push,
  output job_t                       job,
  output logic                       ram_we,
  output logic [$clog2((2*MAX_HALF+2)*MAX_WIDTH)-1:0] ram_waddr,
  output logic [PIX_W-1:0]           ram_wdata
);

  localparam int SLOTS  = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int AW     = $clog2(SLOTS * MAX_WIDTH);
  localparam int HW     = $clog2(MAX_HALF + 1);
  localparam int DIM_W  = $clog2(2 * MAX_HALF + 2);

  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [3:0]  half_height;
  logic [3:0]  half_width;
  logic [16:0] ratio_q16;

  logic [ROW_W-1:0]  in_row, out_row;
  logic [WD_W-1:0]   in_col, out_col;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [AW-1:0]     in_base;

  logic [WD_W-1:0]   wd;
  logic [ROW_W-1:0]  ht, ht_m1;
  logic [HW-1:0]     h, w;
  logic [GAIN_W-1:0] f;

  logic              accept, store;
  logic [ROW_W-1:0]  in_row_next;
  logic [WD_W-1:0]   in_col_next;
  logic              in_row_wrap;
  logic [ROW_W:0]    br_sum;
  logic [WD_W:0]     bc_sum;
  logic [ROW_W-1:0]  br, tr;
  logic [WD_W-1:0]   bc, tc;
  logic [HW-1:0]     d;
  logic [SLOT_W-1:0] tslot;
  logic              ready;
  logic              last;

  assign wd = (image_width == '0) ? WD_W'(1) :
              (32'(image_width) > MAX_WIDTH) ? WD_W'(MAX_WIDTH) : WD_W'(image_width);
  assign ht    = (image_height == '0) ? ROW_W'(1) : image_height;
  assign ht_m1 = ht - ROW_W'(1);
  assign h = (32'(half_height) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_height);
  assign w = (32'(half_width) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_width);
  assign f = (ratio_q16 > ONE_Q16) ? ONE_Q16 : ratio_q16;

  assign s_tready = q_empty && !back_busy;
  assign accept   = s_tvalid && s_tready;
  assign store    = accept && (s_tuser == MODE_PIXEL) && (in_row < ht);

  assign ram_we    = store;
  assign ram_waddr = in_base + AW'(in_col);
  assign ram_wdata = s_tdata;

  always_comb begin
    in_row_next = in_row;
    in_col_next = in_col;
    in_row_wrap = 1'b0;
    if (store) begin
      if ((in_col + WD_W'(1)) >= wd) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_W'(1);
        in_row_wrap = 1'b1;
      end else begin
        in_col_next = in_col + WD_W'(1);
      end
    end
  end

  always_comb begin
    br_sum = {1'b0, out_row} + (ROW_W+1)'(h);
    br     = (br_sum > {1'b0, ht_m1}) ? ht_m1 : br_sum[ROW_W-1:0];
    bc_sum = {1'b0, out_col} + (WD_W+1)'(w);
    bc     = (bc_sum > {1'b0, wd - WD_W'(1)}) ? (wd - WD_W'(1)) : bc_sum[WD_W-1:0];
    tr     = (out_row > ROW_W'(h)) ? (out_row - ROW_W'(h)) : '0;
    tc     = (out_col > WD_W'(w)) ? (out_col - WD_W'(w)) : '0;
    d      = HW'(out_row - tr);
    tslot  = (out_slot >= SLOT_W'(d)) ? (out_slot - SLOT_W'(d)) :
             (out_slot + SLOT_W'(SLOTS) - SLOT_W'(d));
    ready  = (in_row_next > br) || ((in_row_next == br) && (in_col_next > bc));
    last   = ((out_col + WD_W'(1)) >= wd) && ((out_row + ROW_W'(1)) >= ht);
  end

  assign push = accept && ready;

  always_comb begin
    job       = '0;
    job.tr    = tr;
    job.br    = br;
    job.tc    = tc;
    job.bc    = bc;
    job.orow  = out_row;
    job.ocol  = out_col;
    job.tslot = tslot;
    job.nrows = DIM_W'(br - tr) + DIM_W'(1);
    job.ncols = DIM_W'(bc - tc) + DIM_W'(1);
    job.gain  = ONE_Q16 - f;
    job.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      half_height  <= HALF_HEIGHT_RST;
      half_width   <= HALF_WIDTH_RST;
      ratio_q16    <= RATIO_Q16_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata[10:0];
        REG_HALF_HEIGHT:  half_height  <= cfg_wdata[3:0];
        REG_HALF_WIDTH:   half_width   <= cfg_wdata[3:0];
        REG_RATIO_Q16:    ratio_q16    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_wen && (cfg_addr <= REG_RATIO_Q16);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (push && last)) begin
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      in_base  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
    end else begin
      in_row <= in_row_next;
      in_col <= in_col_next;
      if (in_row_wrap) begin
        if (32'(in_slot) == SLOTS - 1) begin
          in_slot <= '0;
          in_base <= '0;
        end else begin
          in_slot <= in_slot + SLOT_W'(1);
          in_base <= in_base + AW'(MAX_WIDTH);
        end
      end
      if (push) begin
        if ((out_col + WD_W'(1)) >= wd) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
          out_slot <= (32'(out_slot) == SLOTS - 1) ? '0 : (out_slot + SLOT_W'(1));
        end else begin
          out_col <= out_col + WD_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/amt_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amt_back
// window scan over the row store, threshold compare and output register
// ---------------------------------------------------------------------------
module amt_back
  import amt_pkg::*;
#(
  parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int  MAX_HALF  = MAX_HALF_DEF,
  parameter type job_t     = logic
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  job_t                  q_head,
  output logic                  pop,
  output logic                  busy,
  output logic [$clog2((2*MAX_HALF+2)*MAX_WIDTH)-1:0] ram_raddr,
  input  wire logic [PIX_W-1:0] ram_rdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [PIX_W-1:0]      m_tdata,
  output logic                  m_tlast
);

  localparam int SLOTS  = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int AW     = $clog2(SLOTS * MAX_WIDTH);
  localparam int CNT_W  = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
  localparam int SUM_W  = CNT_W + PIX_W;
  localparam int PA_W   = CNT_W + PIX_W;
  localparam int PB_W   = SUM_W + GAIN_W;

  back_state_t state, state_next;

  job_t              cur;
  logic [ROW_W-1:0]  r;
  logic [WD_W-1:0]   c;
  logic [SLOT_W-1:0] slot;
  logic [AW-1:0]     base;
  logic              v_d, ctr_d;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [PIX_W-1:0]  px;
  logic [PA_W-1:0]   prod_a;
  logic [PB_W-1:0]   prod_b;
  logic              out_free;
  logic              below;

  assign busy      = (state != B_IDLE);
  assign ram_raddr = base + AW'(c);
  assign out_free  = !m_tvalid || m_tready;
  assign below     = {1'b0, prod_a, 16'b0} < prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if ((c == cur.bc) && (r == cur.br)) begin
          state_next = B_TAIL;
        end
      end
      B_TAIL: state_next = B_MUL;
      B_MUL:  state_next = B_DONE;
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_d   <= (state == B_SCAN);
    ctr_d <= (state == B_SCAN) && (r == cur.orow) && (c == cur.ocol);
    if (v_d) begin
      sum <= sum + SUM_W'(ram_rdata);
    end
    if (ctr_d) begin
      px <= ram_rdata;
    end
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cur   <= q_head;
          r     <= q_head.tr;
          c     <= q_head.tc;
          slot  <= q_head.tslot;
          base  <= AW'(32'(q_head.tslot) * MAX_WIDTH);
          sum   <= '0;
          count <= CNT_W'(q_head.nrows) * CNT_W'(q_head.ncols);
        end
      end
      B_SCAN: begin
        if (c == cur.bc) begin
          if (r != cur.br) begin
            c <= cur.tc;
            r <= r + ROW_W'(1);
            if (32'(slot) == SLOTS - 1) begin
              slot <= '0;
              base <= '0;
            end else begin
              slot <= slot + SLOT_W'(1);
              base <= base + AW'(MAX_WIDTH);
            end
          end
        end else begin
          c <= c + WD_W'(1);
        end
      end
      B_MUL: begin
        prod_a <= PA_W'(px) * PA_W'(count);
        prod_b <= PB_W'(cur.gain) * PB_W'(sum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == B_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_DONE) && out_free) begin
      m_tdata <= below ? PIX_BLACK : PIX_WHITE;
      m_tlast <= cur.last;
    end
  end

endmodule
`default_nettype wire
